// ===== hdl/ksmc_pkg.sv =====
// Shared types and constants for the k-step minimum cost path block.
// No dependencies; imported by every module under hdl.
`default_nettype none

package ksmc_pkg;

	// Cost and candidate widths, fixed by the output field
	localparam int COST_W = 32;
	localparam int CAND_W = COST_W + 1;

	// Register map
	localparam logic REG_JUMP_WINDOW = 1'b0;
	localparam int   JW_W            = 5;
	localparam logic [JW_W-1:0] JW_RESET = 5'd2;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_REDUCE,
		S_WRITE
	} state_t;

	// Min tree control from the sequencer
	typedef struct packed {
		logic load;
		logic step;
	} tree_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/ksmc_cell.sv =====
// One history cell: holds a stored height and cost, forms its jump candidate.
// Depends on ksmc_pkg.
`default_nettype none

module ksmc_cell import ksmc_pkg::*; #(
	parameter int HEIGHT_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   shift,
	input  wire logic [HEIGHT_BITS-1:0] in_height,
	input  wire logic [COST_W-1:0]      in_cost,
	input  wire logic [HEIGHT_BITS-1:0] cur_height,
	input  wire logic                   enable,
	output logic      [HEIGHT_BITS-1:0] height_q,
	output logic      [COST_W-1:0]      cost_q,
	output logic      [CAND_W-1:0]      cand
);

	logic [HEIGHT_BITS-1:0] diff;

	// History entry, handed on to the next cell on each push
	always_ff @(posedge clk) begin
		if (shift) begin
			height_q <= in_height;
			cost_q   <= in_cost;
		end
	end

	// Candidate: stored cost plus absolute height step; out of window reads as max
	always_comb begin
		diff = (cur_height >= height_q) ? (cur_height - height_q) : (height_q - cur_height);
		if (enable) begin
			cand = {1'b0, cost_q} + CAND_W'(diff);
		end else begin
			cand = '1;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ksmc_min_tree.sv =====
// Registered min reduction over the cell candidates, halved in place each step.
// Depends on ksmc_pkg.
`default_nettype none

module ksmc_min_tree import ksmc_pkg::*; #(
	parameter int MAX_WINDOW = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tree_ctrl_t            ctrl,
	input  wire logic [CAND_W-1:0]     cand [MAX_WINDOW],
	output logic                       last,
	output logic      [CAND_W-1:0]     best
);

	localparam int LVL    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int LEAVES = 1 << LVL;
	localparam int CNT_W  = $clog2(LVL + 1);

	logic [CAND_W-1:0] node_q [LEAVES];
	logic [CNT_W-1:0]  step_cnt_q;

	// Step counter: last is high during the final halving step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cnt_q <= '0;
		end else if (ctrl.load) begin
			step_cnt_q <= '0;
		end else if (ctrl.step) begin
			step_cnt_q <= step_cnt_q + 1'b1;
		end
	end

	assign last = (step_cnt_q == CNT_W'(LVL - 1));
	assign best = node_q[0];

	// Leaves: load from the cells, or fold pairs into the lower half
	for (genvar i = 0; i < LEAVES; i++) begin : g_node
		always_ff @(posedge clk) begin
			if (ctrl.load) begin
				if (i < MAX_WINDOW) begin
					node_q[i] <= cand[(i < MAX_WINDOW) ? i : 0];
				end else begin
					node_q[i] <= '1;
				end
			end else if (ctrl.step && (i < LEAVES / 2)) begin
				node_q[i] <= (node_q[(2*i) % LEAVES] <= node_q[(2*i+1) % LEAVES])
					? node_q[(2*i) % LEAVES] : node_q[(2*i+1) % LEAVES];
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/k_step_min_cost_path.sv =====
// k_step_min_cost_path: each input item carries one height; the block returns
// one item with the minimum cost of reaching that position, jumping back 1 to
// jump_window places at a cost of the absolute height step. An item with
// tuser set starts a new sequence at cost 0. Costs saturate at 2^32-1 and
// m_tuser flags a saturated cost. Each item goes through accept, candidate
// load from the cell chain, one min tree step per level, then the push into
// the chain; no new item is accepted before the push, since every cost feeds
// the candidate of the next item. The next item may be accepted while the
// previous result waits on m_tready. No clearing pass.
// Depends on ksmc_pkg, ksmc_cell, ksmc_min_tree.
`default_nettype none

module k_step_min_cost_path import ksmc_pkg::*; #(
	parameter int MAX_WINDOW  = 16,
	parameter int HEIGHT_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((HEIGHT_BITS+7)/8)*8-1:0]    s_tdata,   // [HEIGHT_BITS-1:0] height
	input  wire logic                                s_tuser,   // [0] first
	// result stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [COST_W-1:0]                   m_tdata,   // [31:0] cost
	output logic                                     m_tuser,   // [0] overflow
	// configuration
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [2:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output logic      [31:0]                         prdata,
	output logic                                     pready
);

	localparam int CW = $clog2(MAX_WINDOW + 1);

	state_t state_q, state_d;
	tree_ctrl_t tree_ctrl;

	logic [JW_W-1:0]        jw_q;
	logic [HEIGHT_BITS-1:0] cur_height_q;
	logic [CW-1:0]          valid_count_q;
	logic [CW-1:0]          k_q;
	logic [CW-1:0]          kwin, cnt_eff, k_d;
	logic                   accept, push, tree_last;
	logic [CAND_W-1:0]      cand [MAX_WINDOW];
	logic [CAND_W-1:0]      best;
	logic [HEIGHT_BITS-1:0] hist_h [MAX_WINDOW];
	logic [COST_W-1:0]      hist_c [MAX_WINDOW];
	logic [COST_W-1:0]      new_cost;
	logic                   new_ovf;
	logic                   m_tvalid_q;
	logic [COST_W-1:0]      m_cost_q;
	logic                   m_ovf_q;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_JUMP_WINDOW) ? {{(32-JW_W){1'b0}}, jw_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jw_q <= JW_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_JUMP_WINDOW)) begin
			jw_q <= pwdata[JW_W-1:0];
		end
	end

	// Effective window: clamp to 1..MAX_WINDOW, then to the history length
	always_comb begin
		if (jw_q == '0) begin
			kwin = CW'(1);
		end else if (int'(jw_q) > MAX_WINDOW) begin
			kwin = CW'(MAX_WINDOW);
		end else begin
			kwin = CW'(jw_q);
		end
		cnt_eff = s_tuser ? '0 : valid_count_q;
		k_d     = (kwin < cnt_eff) ? kwin : cnt_eff;
	end

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and tree control
	always_comb begin
		state_d        = state_q;
		tree_ctrl.load = 1'b0;
		tree_ctrl.step = 1'b0;
		push           = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_LOAD;
			end
			S_LOAD: begin
				tree_ctrl.load = 1'b1;
				state_d        = S_REDUCE;
			end
			S_REDUCE: begin
				tree_ctrl.step = 1'b1;
				if (tree_last) state_d = S_WRITE;
			end
			S_WRITE: begin
				if (!m_tvalid_q || m_tready) begin
					push    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Item registers and history length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_count_q <= '0;
			k_q           <= '0;
		end else if (accept) begin
			valid_count_q <= cnt_eff;
			k_q           <= k_d;
		end else if (push && (valid_count_q < CW'(MAX_WINDOW))) begin
			valid_count_q <= valid_count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) cur_height_q <= s_tdata[HEIGHT_BITS-1:0];
	end

	// Cell chain, newest entry in cell 0
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic [HEIGHT_BITS-1:0] in_h;
		logic [COST_W-1:0]      in_c;
		if (i == 0) begin : g_head
			assign in_h = cur_height_q;
			assign in_c = new_cost;
		end else begin : g_link
			assign in_h = hist_h[(i > 0) ? i - 1 : 0];
			assign in_c = hist_c[(i > 0) ? i - 1 : 0];
		end
		ksmc_cell #(
			.HEIGHT_BITS(HEIGHT_BITS)
		) u_cell (
			.clk       (clk),
			.shift     (push),
			.in_height (in_h),
			.in_cost   (in_c),
			.cur_height(cur_height_q),
			.enable    (CW'(i) < k_q),
			.height_q  (hist_h[i]),
			.cost_q    (hist_c[i]),
			.cand      (cand[i])
		);
	end

	ksmc_min_tree #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_tree (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (tree_ctrl),
		.cand  (cand),
		.last  (tree_last),
		.best  (best)
	);

	// Saturate; an empty history gives cost 0
	always_comb begin
		if (k_q == '0) begin
			new_cost = '0;
			new_ovf  = 1'b0;
		end else if (best[CAND_W-1]) begin
			new_cost = '1;
			new_ovf  = 1'b1;
		end else begin
			new_cost = best[COST_W-1:0];
			new_ovf  = 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			m_cost_q <= new_cost;
			m_ovf_q  <= new_ovf;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_cost_q;
	assign m_tuser  = m_ovf_q;

	// Checks
	a_rise_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_WRITE))
		else $error("result appeared outside the write step");

	a_window_in_history: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (k_q <= valid_count_q))
		else $error("jump window exceeds history length");

	a_push_fills_history: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (valid_count_q != '0))
		else $error("history empty after a push");

	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '1))
		else $error("overflow flagged on an unsaturated cost");

endmodule

`default_nettype wire

// ===== test/k_step_min_cost_path_tb.sv =====
`timescale 1ns / 100ps
// Testbench for k_step_min_cost_path: streams heights in, predicts the minimum
// path cost of every position and checks each result item in order.
// Depends on ksmc_pkg and the k_step_min_cost_path RTL; self-contained otherwise.

module k_step_min_cost_path_tb;
	import ksmc_pkg::*;

	localparam int MAX_WINDOW     = 16;
	localparam int HEIGHT_BITS    = 16;
	localparam int TDATA_W        = ((HEIGHT_BITS + 7) / 8) * 8;
	localparam int LIMIT_CYCLES   = 3_000_000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int SHOWN_ERRORS   = 40;
	localparam int PHASE_ITEMS    = 200;
	localparam int RESET_CYCLES   = 7;
	localparam logic [2:0] ADDR_JUMP_WINDOW = {REG_JUMP_WINDOW, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;
	localparam logic [COST_W-1:0] COST_TOP  = '1;
	localparam logic [HEIGHT_BITS-1:0] H_TOP = '1;

	typedef struct packed {
		logic [HEIGHT_BITS-1:0] height;
		logic                   first;
	} height_item_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              overflow;
	} cost_item_t;

	typedef enum int {HS_FULL, HS_NARROW, HS_EXTREME, HS_RAMP, HS_NOISE} height_style_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	// Block ports
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	wire  s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;   // [15:0] height
	logic s_tuser = 1'b0;               // [0] first
	wire  m_tvalid;
	logic m_tready = 1'b0;
	wire  [COST_W-1:0] m_tdata;         // [31:0] cost
	wire  m_tuser;                      // [0] overflow
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire  pready;

	// Predictor state: window setting and shift history, newest first
	logic [JW_W-1:0] jump_setting = JW_RESET;
	logic [HEIGHT_BITS-1:0] past_height [MAX_WINDOW];
	logic [COST_W-1:0] past_cost [MAX_WINDOW];
	int path_depth = 0;

	height_item_t height_q[$];
	cost_item_t cost_q[$];

	// Stream pacing
	logic in_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int mode_left = 0;
	int holdoff_left = 0;
	logic holdoff_arm = 1'b0;

	int mismatch_count = 0;
	int cycle_count = 0;

	k_step_min_cost_path #(
		.MAX_WINDOW (MAX_WINDOW),
		.HEIGHT_BITS(HEIGHT_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Minimum cost of the next position; updates the history as the block does
	function automatic cost_item_t advance_path(input logic [HEIGHT_BITS-1:0] h,
			input logic is_first);
		cost_item_t res;
		logic [COST_W:0] best;
		logic [COST_W:0] cand;
		logic [HEIGHT_BITS-1:0] rise;
		int reach;
		int d;
		res.cost = '0;
		res.overflow = 1'b0;
		if (is_first)
			path_depth = 0;
		if (path_depth != 0) begin
			// window of 0 behaves as 1, above the maximum as the maximum, above the history depth as that depth
			reach = (jump_setting == 0) ? 1 : int'(jump_setting);
			if (reach > MAX_WINDOW)
				reach = MAX_WINDOW;
			if (reach > path_depth)
				reach = path_depth;
			best = '1;
			for (d = 0; d < reach; d++) begin
				rise = (h >= past_height[d]) ? h - past_height[d] : past_height[d] - h;
				cand = {1'b0, past_cost[d]} + (COST_W+1)'(rise);
				if (cand < best)
					best = cand;
			end
			if (best > {1'b0, COST_TOP}) begin
				res.cost = COST_TOP;
				res.overflow = 1'b1;
			end else begin
				res.cost = best[COST_W-1:0];
			end
		end
		for (d = MAX_WINDOW - 1; d > 0; d--) begin
			past_height[d] = past_height[d-1];
			past_cost[d] = past_cost[d-1];
		end
		past_height[0] = h;
		past_cost[0] = res.cost;
		if (path_depth < MAX_WINDOW)
			path_depth++;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= SHOWN_ERRORS)
			$display("%0t: mismatch: %s", $time, what);
	endtask

	// Input accept feeds the predictor; result accept is checked against it
	always @(posedge clk) begin
		cost_item_t want;
		if (arst_n) begin
			if (m_tvalid === 1'b1 && m_tready) begin
				if (cost_q.size() == 0) begin
					report_mismatch($sformatf("cost %0d with no item pending", m_tdata));
				end else begin
					want = cost_q.pop_front();
					if (m_tdata !== want.cost)
						report_mismatch($sformatf("cost %0d, want %0d", m_tdata, want.cost));
					if (m_tuser !== want.overflow)
						report_mismatch($sformatf("overflow %b, want %b (cost %0d)",
							m_tuser, want.overflow, want.cost));
				end
			end
			in_taken <= s_tvalid && s_tready === 1'b1;
			if (s_tvalid && s_tready === 1'b1)
				cost_q.push_back(advance_path(s_tdata[HEIGHT_BITS-1:0], s_tuser));
		end
	end

	// Sender: bursts of items with random gaps, holding until accepted
	always @(negedge clk) begin
		logic offer;
		height_item_t nxt;
		if (arst_n && !(s_tvalid && !in_taken)) begin
			offer = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
			end else if (height_q.size() != 0) begin
				nxt = height_q.pop_front();
				offer = 1'b1;
				s_tdata <= TDATA_W'(nxt.height);
				s_tuser <= nxt.first;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
						: $urandom_range(0, 3);
				end
			end
			s_tvalid <= offer;
		end
	end

	// Receiver: stall pattern changes mode every so often
	always @(negedge clk) begin
		logic ready;
		if (mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(30, 200);
		end else begin
			mode_left--;
		end
		case (rx_mode)
			RX_OPEN: ready = 1'b1;
			RX_COIN: ready = 1'($urandom_range(0, 1));
			RX_SPARSE: ready = ($urandom_range(0, 4) == 0);
			default: ready = ~m_tready;
		endcase
		m_tready <= ready && holdoff_left == 0;
	end

	// Long receiver hold-off, counted here once armed
	always @(negedge clk) begin
		if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_arm) begin
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_arm <= 1'b0;
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic queue_height(input logic [HEIGHT_BITS-1:0] h, input logic is_first);
		height_item_t it;
		it.height = h;
		it.first = is_first;
		height_q.push_back(it);
	endtask

	// Wait until every item is accepted and every result has come back
	task automatic drain_results();
		do @(posedge clk); while (height_q.size() != 0 || s_tvalid);
		do @(negedge clk); while (cost_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB write: setup then access, register taken when pready is high
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (addr == ADDR_JUMP_WINDOW)
			jump_setting = data[JW_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Random sequences; most start with a first flag, noise runs break the rule
	task automatic load_sequences(input int n_items);
		int left;
		int run;
		int i;
		height_style_t style;
		logic [HEIGHT_BITS-1:0] base;
		logic [HEIGHT_BITS-1:0] h;
		logic is_first;
		left = n_items;
		while (left > 0) begin
			run = $urandom_range(1, 40);
			if (run > left)
				run = left;
			style = height_style_t'($urandom_range(0, 4));
			base = HEIGHT_BITS'($urandom);
			for (i = 0; i < run; i++) begin
				case (style)
					HS_NARROW: h = HEIGHT_BITS'(base + $urandom_range(0, 15));
					HS_EXTREME: h = $urandom_range(0, 1) ? H_TOP : '0;
					HS_RAMP: h = HEIGHT_BITS'(base + i * $urandom_range(1, 4000));
					default: h = HEIGHT_BITS'($urandom);
				endcase
				if (i == 0)
					is_first = (style != HS_NOISE) || $urandom_range(0, 1);
				else
					is_first = (style == HS_NOISE) && ($urandom_range(0, 5) == 0);
				queue_height(h, is_first);
			end
			left -= run;
		end
	endtask

	initial begin
		int i;
		int ph;
		logic [JW_W-1:0] windows [8];
		windows = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd8, 5'd2, 5'd17};
		windows[4] = JW_W'($urandom_range(0, 31));
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Reset window; first item without a first flag on empty history
		queue_height(16'h1234, 1'b0);
		queue_height('0, 1'b0);
		queue_height(H_TOP, 1'b0);
		queue_height('0, 1'b0);
		queue_height(H_TOP, 1'b1);
		queue_height(16'h8000, 1'b0);
		queue_height(16'h7FFF, 1'b0);
		queue_height(16'hAAAA, 1'b0);
		drain_results();

		// Window zero behaves as one
		write_reg(ADDR_JUMP_WINDOW, 32'hFFFF_FFE0);
		queue_height(16'h5555, 1'b1);
		queue_height('0, 1'b0);
		queue_height(H_TOP, 1'b0);
		queue_height(16'h0001, 1'b0);
		drain_results();

		// Write beyond the register map must leave the window alone
		write_reg(ADDR_UNMAPPED, 32'h0000_0010);
		queue_height(16'h0100, 1'b0);
		queue_height(16'h0300, 1'b0);
		drain_results();

		// Window above the history depth clamps to it
		write_reg(ADDR_JUMP_WINDOW, 32'h0000_0011);
		queue_height(16'd100, 1'b1);
		for (i = 1; i < 7; i++)
			queue_height(i[0] ? 16'hF000 : HEIGHT_BITS'(100 + i), 1'b0);
		drain_results();
		write_reg(ADDR_JUMP_WINDOW, 32'hFFFF_FFFF);
		queue_height('0, 1'b0);
		queue_height(H_TOP, 1'b0);
		queue_height(16'd7, 1'b0);
		drain_results();

		// Random phases across window settings
		for (ph = 0; ph < 8; ph++) begin
			write_reg(ADDR_JUMP_WINDOW, (32'($urandom) & ~32'h1F) | 32'(windows[ph]));
			load_sequences(PHASE_ITEMS);
			if (ph == 2)
				holdoff_arm = 1'b1;
			drain_results();
		end

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ksmc_pkg.sv
hdl/ksmc_cell.sv
hdl/ksmc_min_tree.sv
hdl/k_step_min_cost_path.sv
test/k_step_min_cost_path_tb.sv
